// ===== sv/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds the action and state enums, character codes and the
// command and status structs between controller and datapath.
package tcw_pkg;

   // Action codes carried by an input word.
   typedef enum logic [1:0] {
      ACTION_PUT   = 2'd0,
      ACTION_CLEAR = 2'd1,
      ACTION_READ  = 2'd2
   } action_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_CLEAR,
      ST_DONE
   } ctrl_state_type;

   // Control bytes and the blank character.
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [7:0] CHAR_RETURN    = 8'h0d;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   // Configuration register indexes and reset values.
   localparam logic       CSR_SCROLL_FILL = 1'b0;
   localparam logic       CSR_CLEAR_FILL  = 1'b1;
   localparam logic [7:0] SCROLL_FILL_RESET = 8'h07;
   localparam logic [7:0] CLEAR_FILL_RESET  = 8'h0f;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic put_step;
      logic read_issue;
      logic clear_start;
      logic clear_step;
      logic scroll_start;
      logic copy_step;
      logic fill_start;
      logic fill_step;
      logic tab_next;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       is_tab;
      logic       row_over;
      logic       tab_last;
      logic       copy_last;
      logic       sweep_end;
   } dp_status_type;

endpackage

// ===== sv/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
// Sequences put, clear, read and scroll work; owns the handshake state.
// Depends on tcw_pkg.
module tcw_ctrl import tcw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_free;

   // The output register can take a new word when empty or being drained.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (status.action)
               ACTION_PUT:   state_in = ST_CHECK;
               ACTION_CLEAR: state_in = ST_CLEAR;
               default:      state_in = ST_DONE;
            endcase
         end
         ST_CHECK: begin
            if (status.row_over) state_in = ST_COPY;
            else if (status.is_tab && !status.tab_last) state_in = ST_EXEC;
            else state_in = ST_DONE;
         end
         ST_COPY: begin
            if (status.copy_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_FILL;
         ST_FILL: begin
            if (status.sweep_end) state_in = ST_CHECK;
         end
         ST_CLEAR: begin
            if (status.sweep_end) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands issued in each state.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: cmd.load_item = req_valid;
         ST_EXEC: begin
            case (status.action)
               ACTION_PUT:   cmd.put_step = 1'b1;
               ACTION_CLEAR: cmd.clear_start = 1'b1;
               ACTION_READ:  cmd.read_issue = 1'b1;
               default:      cmd = '0;
            endcase
         end
         ST_CHECK: begin
            if (status.row_over) cmd.scroll_start = 1'b1;
            else if (status.is_tab && !status.tab_last) cmd.tab_next = 1'b1;
         end
         ST_COPY:  cmd.copy_step = 1'b1;
         ST_DRAIN: cmd.fill_start = 1'b1;
         ST_FILL:  cmd.fill_step = 1'b1;
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_DONE:  cmd.load_rsp = rsp_free;
         default:  cmd = '0;
      endcase
   end

   // Output valid flag follows loads and downstream takes.
   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/tcw_datapath.sv =====
// Datapath of the text console writer: cell memory, cursor, sweep
// counter, configuration registers and the result register.
// Depends on tcw_pkg; driven by tcw_ctrl commands.
module tcw_datapath import tcw_pkg::*; #(
   parameter int COLS       = 80,
   parameter int ROWS       = 25,
   parameter int TAB_SPACES = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [1:0]    req_action,
   input  logic [7:0]    req_char_code,
   input  logic [7:0]    req_char_attribute,
   input  logic [10:0]   req_read_address,
   input  logic          csr_valid,
   input  logic          csr_index,
   input  logic [7:0]    csr_data,
   output logic [6:0]    rsp_cursor_column,
   output logic [4:0]    rsp_cursor_row,
   output logic [10:0]   rsp_cursor_linear,
   output logic [15:0]   rsp_cell_word,
   output logic          rsp_scrolled
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int LIN_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS + 1);
   localparam int TAB_W  = $clog2(TAB_SPACES + 1);

   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [ROW_W-1:0]  ROW_PAST   = ROW_W'(ROWS);
   localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLS - 1);
   localparam logic [ADDR_W-1:0] FILL_FIRST = ADDR_W'(CELLS - COLS);
   localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLS);
   localparam logic [TAB_W-1:0]  TAB_LAST   = TAB_W'(TAB_SPACES - 1);

   // Item fields held for the duration of the item.
   action_type        action_ff;
   logic [7:0]        code_ff;
   logic [7:0]        attr_ff;
   logic [10:0]       addr_ff;

   // Cursor, sweep and flags.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic [TAB_W-1:0]  tab_cnt_ff;
   logic              scrolled_ff;
   logic              hit_ff;
   logic              copy_pend_ff;
   logic [ADDR_W-1:0] copy_waddr_ff;
   logic [7:0]        scroll_attr_ff;
   logic [7:0]        clear_attr_ff;

   // Memory and its ports.
   logic [15:0]       cell_mem_ff [CELLS];
   logic [15:0]       rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;

   // Put-step signals.
   logic [LIN_W-1:0]  pos_lin;
   logic [ADDR_W-1:0] pos;
   logic [7:0]        put_char;
   logic              put_we;
   logic [ADDR_W-1:0] put_addr;
   logic [15:0]       put_data;
   logic              is_tab;
   logic              addr_in_range;

   // Linear cursor position.
   assign pos_lin = LIN_W'(row_ff) * LIN_W'(COLS) + LIN_W'(col_ff);
   assign pos     = pos_lin[ADDR_W-1:0];

   assign is_tab        = (code_ff == CHAR_TAB);
   assign put_char      = is_tab ? CHAR_BLANK : code_ff;
   assign addr_in_range = (32'(addr_ff) < 32'(CELLS));

   // Status back to the controller.
   assign status.action    = action_ff;
   assign status.is_tab    = is_tab;
   assign status.row_over  = (row_ff == ROW_PAST);
   assign status.tab_last  = (tab_cnt_ff == TAB_LAST);
   assign status.copy_last = (sweep_ff == COPY_LAST);
   assign status.sweep_end = (sweep_ff == CELL_LAST);

   // Cursor update and the cell written by one put step.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      put_we   = 1'b0;
      put_addr = pos;
      put_data = {attr_ff, put_char};
      if (cmd.put_step) begin
         case (put_char)
            CHAR_BACKSPACE: begin
               if (col_ff != '0) begin
                  col_in   = col_ff - 1'b1;
                  put_we   = 1'b1;
                  put_addr = pos - 1'b1;
                  put_data = {attr_ff, CHAR_BLANK};
               end
            end
            CHAR_NEWLINE: begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end
            CHAR_RETURN: col_in = '0;
            default: begin
               put_we = 1'b1;
               if (col_ff == COL_LAST) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         endcase
      end else if (cmd.scroll_start) begin
         row_in = ROW_LAST;
      end else if (cmd.clear_start) begin
         col_in = '0;
         row_in = '0;
      end
   end

   // Sweep counter for clear, scroll copy and scroll fill.
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.clear_start || cmd.scroll_start) sweep_in = '0;
      else if (cmd.fill_start) sweep_in = FILL_FIRST;
      else if (cmd.copy_step || cmd.fill_step || cmd.clear_step) sweep_in = sweep_ff + 1'b1;
   end

   // Memory port selection; the controller keeps the writers exclusive.
   always_comb begin
      rd_en   = cmd.copy_step || (cmd.read_issue && addr_in_range);
      rd_addr = cmd.copy_step ? (sweep_ff + ROW_STEP) : ADDR_W'(addr_ff);
      wr_en   = 1'b0;
      wr_addr = put_addr;
      wr_data = put_data;
      if (put_we) begin
         wr_en = 1'b1;
      end else if (copy_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = copy_waddr_ff;
         wr_data = rd_data_ff;
      end else if (cmd.fill_step) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = {scroll_attr_ff, CHAR_BLANK};
      end else if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = {clear_attr_ff, CHAR_BLANK};
      end
   end

   // Cell memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) cell_mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= cell_mem_ff[rd_addr];
   end

   // Item fields.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         action_ff <= action_type'(req_action);
         code_ff   <= req_char_code;
         attr_ff   <= req_char_attribute;
         addr_ff   <= req_read_address;
      end
      copy_waddr_ff <= sweep_ff;
   end

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         sweep_ff     <= '0;
         tab_cnt_ff   <= '0;
         scrolled_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         copy_pend_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         sweep_ff     <= sweep_in;
         copy_pend_ff <= cmd.copy_step;
         if (cmd.load_item) tab_cnt_ff <= '0;
         else if (cmd.tab_next) tab_cnt_ff <= tab_cnt_ff + 1'b1;
         if (cmd.load_item) scrolled_ff <= 1'b0;
         else if (cmd.scroll_start) scrolled_ff <= 1'b1;
         if (cmd.load_item) hit_ff <= 1'b0;
         else if (cmd.read_issue) hit_ff <= addr_in_range;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_attr_ff <= SCROLL_FILL_RESET;
         clear_attr_ff  <= CLEAR_FILL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCROLL_FILL: scroll_attr_ff <= csr_data;
            CSR_CLEAR_FILL:  clear_attr_ff  <= csr_data;
            default:         scroll_attr_ff <= scroll_attr_ff;
         endcase
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_cursor_column <= 7'(col_ff);
         rsp_cursor_row    <= 5'(row_ff);
         rsp_cursor_linear <= 11'(pos_lin);
         rsp_cell_word     <= hit_ff ? rd_data_ff : 16'h0000;
         rsp_scrolled      <= scrolled_ff;
      end
   end

endmodule

// ===== sv/text_console_writer.sv =====
// Top level of the text console writer.
// Joins tcw_ctrl and tcw_datapath; depends on tcw_pkg.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_stall  | action, code, attribute, read address
//   rsp     | out       | rsp_valid/rsp_stall  | cursor column/row/linear, cell, scrolled
//   csr     | in        | csr_valid/csr_ready  | register index, write data
//
// A scroll copies every row but the top one up a row and then blanks the bottom row with
// the scroll fill; a clear blanks every cell with the clear fill. Each sweep makes one
// memory write per cycle on the cell store. Reset homes the cursor and loads the default
// fill attributes; the cell store holds garbage until a clear. A new word is accepted
// while a result waits on rsp_stall; the block holds the next result until the output
// register frees.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLS       = 80,
   parameter int ROWS       = 25,
   parameter int TAB_SPACES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_char_attribute,
   input  logic [10:0] req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_linear,
   output logic [15:0] rsp_cell_word,
   output logic        rsp_scrolled,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLS       (COLS),
      .ROWS       (ROWS),
      .TAB_SPACES (TAB_SPACES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_char_attribute (req_char_attribute),
      .req_read_address   (req_read_address),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_linear  (rsp_cursor_linear),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_scrolled       (rsp_scrolled)
   );

endmodule

// ===== sv/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
// Watches only the top-level ports; no package dependency.
module tcw_checker #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_cursor_column,
   input logic [4:0]  rsp_cursor_row
);

   // An accepted word keeps the input side busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");

   // A result never appears in the cycle right after an accept.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   // When a result is loaded the block is ready for the next word.
   a_ready_with_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("input stalled when a result was loaded");

   // The reported cursor lies on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_column) < COLS) && (32'(rsp_cursor_row) < ROWS))
      else $error("cursor off screen");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

endmodule

bind text_console_writer tcw_checker #(
   .COLS (COLS),
   .ROWS (ROWS)
) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_cursor_column (rsp_cursor_column),
   .rsp_cursor_row    (rsp_cursor_row)
);

// ===== verif/tb.sv =====
// Self-checking testbench for text_console_writer: a queue-fed driver, a response monitor
// and an internal screen predictor that tracks cursor, cells and fill attributes.
// Depends on tcw_pkg and the text_console_writer RTL only.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tcw_pkg::*;

   localparam int COLS       = 80;
   localparam int ROWS       = 25;
   localparam int TAB_SPACES = 4;
   localparam int CELL_COUNT = ROWS * COLS;
   localparam int ADDR_TOP   = 2047;

   // The fourth action code is not defined by the block and must change nothing.
   localparam logic [1:0] ACTION_UNUSED = 2'd3;

   localparam int IDLE_PCT       = 22;
   localparam int PHASE_WORDS    = 320;
   localparam int PHASE_COUNT    = 5;
   localparam int HOLDOFF_AT     = 700;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int STALL_LIMIT    = 20000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  code;
      logic [7:0]  attr;
      logic [10:0] address;
   } console_cmd_t;

   typedef struct packed {
      logic [6:0]  column;
      logic [4:0]  row;
      logic [10:0] linear;
      logic [15:0] cell_word;
      logic        scrolled;
   } cursor_report_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [7:0]  req_char_code = '0;
   logic [7:0]  req_char_attribute = '0;
   logic [10:0] req_read_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_linear;
   logic [15:0] rsp_cell_word;
   logic        rsp_scrolled;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_SCROLL_FILL;
   logic [7:0]  csr_data = '0;

   console_cmd_t   pending_cmds[$];
   cursor_report_t expected_reports[$];

   // Predictor state: screen contents, cursor and the two fill attributes.
   logic [15:0] screen_cells [CELL_COUNT];
   int unsigned cursor_col = 0;
   int unsigned cursor_row = 0;
   logic [7:0]  scroll_fill = SCROLL_FILL_RESET;
   logic [7:0]  clear_fill  = CLEAR_FILL_RESET;
   bit          scroll_hit;

   bit req_taken;
   bit steady_traffic;
   bit rsp_holdoff;
   int errors;
   int accepted_cmds;
   int read_cmds;
   int clear_cmds;
   int scroll_reports;
   int settings_used = 1;
   int quiet_cycles;

   always #2 clock = ~clock;

   text_console_writer #(
      .COLS       (COLS),
      .ROWS       (ROWS),
      .TAB_SPACES (TAB_SPACES)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_char_code      (req_char_code),
      .req_char_attribute (req_char_attribute),
      .req_read_address   (req_read_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_linear  (rsp_cursor_linear),
      .rsp_cell_word      (rsp_cell_word),
      .rsp_scrolled       (rsp_scrolled),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Shift the screen up one row and blank the new bottom row.
   function automatic void shift_screen_up();
      int unsigned i;
      for (i = 0; i < CELL_COUNT - COLS; i++) begin
         screen_cells[i] = screen_cells[i + COLS];
      end
      for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
         screen_cells[i] = {scroll_fill, CHAR_BLANK};
      end
      cursor_row = ROWS - 1;
      scroll_hit = 1'b1;
   endfunction

   // Write one glyph at the cursor, advance, wrap at the right edge and scroll at the bottom.
   function automatic void print_glyph(logic [7:0] code, logic [7:0] attr);
      int unsigned pos;
      pos = cursor_row * COLS + cursor_col;
      if (pos < CELL_COUNT) begin
         screen_cells[pos] = {attr, code};
      end
      cursor_col++;
      if (cursor_col >= COLS) begin
         cursor_col = 0;
         cursor_row++;
      end
      if (cursor_row >= ROWS) begin
         shift_screen_up();
      end
   endfunction

   // Apply one accepted word to the screen model and return the report it should produce.
   function automatic cursor_report_t apply_console_cmd(console_cmd_t cmd);
      cursor_report_t rpt;
      logic [15:0] cell_value;
      int unsigned i;
      cell_value = '0;
      scroll_hit = 1'b0;
      case (cmd.action)
         ACTION_PUT: begin
            case (cmd.code)
               CHAR_BACKSPACE: begin
                  // Backspace never leaves the current row.
                  if (cursor_col > 0) begin
                     cursor_col--;
                     screen_cells[cursor_row * COLS + cursor_col] = {cmd.attr, CHAR_BLANK};
                  end
               end
               CHAR_NEWLINE: begin
                  cursor_row++;
                  cursor_col = 0;
                  if (cursor_row >= ROWS) begin
                     shift_screen_up();
                  end
               end
               CHAR_RETURN: begin
                  cursor_col = 0;
               end
               CHAR_TAB: begin
                  repeat (TAB_SPACES) print_glyph(CHAR_BLANK, cmd.attr);
               end
               default: begin
                  print_glyph(cmd.code, cmd.attr);
               end
            endcase
         end
         ACTION_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++) begin
               screen_cells[i] = {clear_fill, CHAR_BLANK};
            end
            cursor_col = 0;
            cursor_row = 0;
         end
         ACTION_READ: begin
            if (cmd.address < CELL_COUNT) begin
               cell_value = screen_cells[cmd.address];
            end
         end
         default: begin
         end
      endcase
      rpt.column    = 7'(cursor_col);
      rpt.row       = 5'(cursor_row);
      rpt.linear    = 11'(cursor_row * COLS + cursor_col);
      rpt.cell_word = cell_value;
      rpt.scrolled  = scroll_hit;
      return rpt;
   endfunction

   function automatic void queue_cmd(logic [1:0] action, logic [7:0] code, logic [7:0] attr,
                                     logic [10:0] address);
      console_cmd_t cmd;
      cmd.action  = action;
      cmd.code    = code;
      cmd.attr    = attr;
      cmd.address = address;
      pending_cmds.push_back(cmd);
   endfunction

   // Random word: mostly text with control bytes, a quarter reads, rare clears and unused actions.
   // In-range reads are only generated after the opening clear, so every cell read has
   // been written.
   function automatic console_cmd_t random_cmd(int unsigned newline_pct);
      console_cmd_t cmd;
      int unsigned pick;
      cmd.code    = 8'($urandom_range(255));
      cmd.attr    = 8'($urandom_range(255));
      cmd.address = 11'($urandom_range(ADDR_TOP));
      pick = $urandom_range(199);
      if (pick < 1) begin
         cmd.action = ACTION_CLEAR;
      end else if (pick < 7) begin
         cmd.action = ACTION_UNUSED;
      end else if (pick < 57) begin
         cmd.action = ACTION_READ;
         if ($urandom_range(9) == 0) begin
            cmd.address = 11'($urandom_range(ADDR_TOP, CELL_COUNT));
         end else begin
            cmd.address = 11'($urandom_range(CELL_COUNT - 1));
         end
      end else begin
         cmd.action = ACTION_PUT;
         pick = $urandom_range(99);
         if (pick < newline_pct) begin
            cmd.code = CHAR_NEWLINE;
         end else if (pick < newline_pct + 4) begin
            cmd.code = CHAR_RETURN;
         end else if (pick < newline_pct + 10) begin
            cmd.code = CHAR_BACKSPACE;
         end else if (pick < newline_pct + 15) begin
            cmd.code = CHAR_TAB;
         end
      end
      return cmd;
   endfunction

   // Write one register once the block takes it, and track it in the predictor.
   task automatic write_csr(logic index, logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_SCROLL_FILL) begin
         scroll_fill = data;
      end else begin
         clear_fill = data;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_reports();
      while (pending_cmds.size() != 0 || expected_reports.size() != 0) @(posedge clock);
   endtask

   // Request side, rising edge: take the accepted word and predict its report.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (pending_cmds[0].action == ACTION_READ) read_cmds++;
         if (pending_cmds[0].action == ACTION_CLEAR) clear_cmds++;
         expected_reports.push_back(apply_console_cmd(pending_cmds.pop_front()));
         req_taken = 1'b1;
         accepted_cmds++;
      end
   end

   // Request side, falling edge: hold a stalled word, otherwise offer the next one or idle.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (pending_cmds.size() != 0 && (steady_traffic || $urandom_range(99) >= IDLE_PCT)) begin
            req_valid          <= 1'b1;
            req_action         <= pending_cmds[0].action;
            req_char_code      <= pending_cmds[0].code;
            req_char_attribute <= pending_cmds[0].attr;
            req_read_address   <= pending_cmds[0].address;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls, plus the long hold-off.
   always @(negedge clock) begin
      rsp_stall <= rsp_holdoff || (!steady_traffic && $urandom_range(99) < IDLE_PCT);
   end

   // One long receiver hold-off so the block fills up and stalls its input.
   initial begin : rsp_pressure
      while (accepted_cmds < HOLDOFF_AT) @(posedge clock);
      rsp_holdoff = 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rsp_holdoff = 1'b0;
   end

   // Monitor: compare every accepted report against the oldest prediction.
   always @(posedge clock) begin : report_check
      cursor_report_t seen;
      cursor_report_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_cursor_column, rsp_cursor_row, rsp_cursor_linear, rsp_cell_word,
                 rsp_scrolled};
         if (expected_reports.size() == 0) begin
            if (errors < MAX_REPORTS) $display("[%0t] report with no word pending", $realtime);
            errors++;
         end else begin
            want = expected_reports.pop_front();
            if (want.scrolled) scroll_reports++;
            if (seen !== want) begin
               if (errors < MAX_REPORTS) begin
                  $display("[%0t] mismatch (expected/actual): column %0d/%0d row %0d/%0d",
                           $realtime, want.column, seen.column, want.row, seen.row);
                  $display("   linear %0d/%0d cell %h/%h scrolled %b/%b", want.linear,
                           seen.linear, want.cell_word, seen.cell_word, want.scrolled,
                           seen.scrolled);
               end
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake on any channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned newline_plan [PHASE_COUNT];
      logic [7:0]  scroll_value;
      logic [7:0]  clear_value;
      newline_plan = '{10, 3, 20, 8, 14};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words, starting before any clear: only out-of-range reads are safe there.
      queue_cmd(ACTION_READ,   8'h00, 8'h00, 11'd2047);
      queue_cmd(ACTION_PUT,    CHAR_BACKSPACE, 8'h55, 11'd0);  // backspace at column zero
      queue_cmd(ACTION_PUT,    8'hff, 8'hff, 11'd2047);
      queue_cmd(ACTION_PUT,    8'h00, 8'h00, 11'd0);
      queue_cmd(ACTION_PUT,    CHAR_TAB, 8'h3c, 11'd1024);
      queue_cmd(ACTION_PUT,    CHAR_BACKSPACE, 8'hc3, 11'd0);
      queue_cmd(ACTION_PUT,    CHAR_RETURN, 8'h00, 11'd0);
      queue_cmd(ACTION_UNUSED, 8'hff, 8'hff, 11'd2047);
      queue_cmd(ACTION_CLEAR,  8'h00, 8'h00, 11'd0);
      queue_cmd(ACTION_PUT,    8'h48, 8'h1f, 11'd0);
      queue_cmd(ACTION_READ,   8'h00, 8'h00, 11'd0);
      queue_cmd(ACTION_READ,   8'hff, 8'hff, 11'(CELL_COUNT - 1));
      queue_cmd(ACTION_READ,   8'h00, 8'h00, 11'(CELL_COUNT));  // first address past the end
      queue_cmd(ACTION_PUT,    CHAR_NEWLINE, 8'h00, 11'd0);
      queue_cmd(ACTION_PUT,    8'h7f, 8'h80, 11'd0);
      queue_cmd(ACTION_PUT,    CHAR_BACKSPACE, 8'h01, 11'd0);
      queue_cmd(ACTION_READ,   8'h00, 8'h00, 11'd80);
      queue_cmd(ACTION_PUT,    CHAR_TAB, 8'he7, 11'd0);
      queue_cmd(ACTION_READ,   8'h00, 8'h00, 11'd81);
      queue_cmd(ACTION_READ,   8'h00, 8'h00, 11'd83);
      queue_cmd(ACTION_PUT,    CHAR_RETURN, 8'h00, 11'd0);
      drain_reports();

      // Random phases, each under its own pair of fill attributes.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               scroll_value = 8'h00;
               clear_value  = 8'hff;
            end
            1: begin
               scroll_value = 8'hff;
               clear_value  = 8'h00;
            end
            4: begin
               scroll_value = SCROLL_FILL_RESET;
               clear_value  = CLEAR_FILL_RESET;
            end
            default: begin
               scroll_value = 8'($urandom_range(255));
               clear_value  = 8'($urandom_range(255));
            end
         endcase
         write_csr(CSR_SCROLL_FILL, scroll_value);
         write_csr(CSR_CLEAR_FILL, clear_value);
         settings_used++;
         // The second phase runs without any idling on either side.
         steady_traffic = (phase == 1);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            pending_cmds.push_back(random_cmd(newline_plan[phase]));
         end
         drain_reports();
      end
      steady_traffic = 1'b0;

      repeat (50) @(posedge clock);
      $display("Covered %0d words (%0d reads, %0d clears) under %0d fill settings;",
               accepted_cmds, read_cmds, clear_cmds, settings_used);
      $display("%0d reports carried a scroll, %0d errors, %0d reports still awaited.",
               scroll_reports, errors, expected_reports.size());
      if (errors == 0 && expected_reports.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
